// ----- rtl/ttc_pkg.sv -----
// ttc_pkg: shared types, constants and lookup functions for the keyword-table cipher.
// Used by ttc_ctrl, ttc_datapath and trisemus_table_cipher; no dependencies.

package ttc_pkg;

  localparam int ALPHA_SIZE = 30;
  localparam int KEY_LENGTH = 6;
  localparam int TABLE_COLS = 6;
  localparam int LETTER_W   = 5;
  localparam int KEY_IDX_W  = 3;
  localparam int CHAR_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 5;
  localparam int OUT_DATA_W = 24;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LAST  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_DIRECTION = 3'd6;

  // row step forward and backward, as table positions
  localparam logic [LETTER_W:0] STEP_DOWN = 6'(TABLE_COLS);
  localparam logic [LETTER_W:0] STEP_UP   = 6'(ALPHA_SIZE - TABLE_COLS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_KEY,
    ST_FILL,
    ST_LOOK,
    ST_POS,
    ST_MAP
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic key_step;
    logic fill_step;
    logic look;
    logic pos;
    logic map_load;
  } cmd_t;

  typedef struct packed {
    logic tbl_ready;
    logic key_fail;
    logic key_last;
    logic fill_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic                hit;
    logic [LETTER_W-1:0] idx;
  } alpha_hit_t;

  // code point of each alphabet letter
  function automatic logic [CHAR_W-1:0] alpha_code(input logic [LETTER_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      5'd0:    c = 16'h0041;
      5'd1:    c = 16'h00C4;
      5'd2:    c = 16'h0042;
      5'd3:    c = 16'h0043;
      5'd4:    c = 16'h0044;
      5'd5:    c = 16'h0045;
      5'd6:    c = 16'h0046;
      5'd7:    c = 16'h0047;
      5'd8:    c = 16'h0048;
      5'd9:    c = 16'h0049;
      5'd10:   c = 16'h004A;
      5'd11:   c = 16'h004B;
      5'd12:   c = 16'h004C;
      5'd13:   c = 16'h004D;
      5'd14:   c = 16'h004E;
      5'd15:   c = 16'h004F;
      5'd16:   c = 16'h00D6;
      5'd17:   c = 16'h0050;
      5'd18:   c = 16'h0051;
      5'd19:   c = 16'h0052;
      5'd20:   c = 16'h0053;
      5'd21:   c = 16'h00DF;
      5'd22:   c = 16'h0054;
      5'd23:   c = 16'h0055;
      5'd24:   c = 16'h00DC;
      5'd25:   c = 16'h0056;
      5'd26:   c = 16'h0057;
      5'd27:   c = 16'h0058;
      5'd28:   c = 16'h0059;
      5'd29:   c = 16'h005A;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  // reverse lookup: code point to alphabet index
  function automatic alpha_hit_t alpha_lookup(input logic [CHAR_W-1:0] c);
    alpha_hit_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (alpha_code(LETTER_W'(i)) == c) begin
        r.hit = 1'b1;
        r.idx = LETTER_W'(i);
      end
    end
    return r;
  endfunction

  // latin-1 upper-casing, sharp s kept, everything above 0xff unchanged
  function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    if (c >= 16'h0061 && c <= 16'h007A) begin
      u = c - 16'h0020;
    end else if (c >= 16'h00E0 && c <= 16'h00FE && c != 16'h00F7) begin
      u = c - 16'h0020;
    end else if (c == 16'h00B5) begin
      u = 16'h039C;
    end else if (c == 16'h00FF) begin
      u = 16'h0178;
    end else begin
      u = c;
    end
    return u;
  endfunction

endpackage

// ----- rtl/ttc_ram.sv -----
// ttc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module ttc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ttc_ctrl.sv -----
// ttc_ctrl: sequencer for table build and per-character lookup.
// Depends on ttc_pkg; drives ttc_datapath through ttc_pkg::cmd_t.

module ttc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ttc_pkg::status_t status,
  output ttc_pkg::cmd_t    cmd
);

  ttc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ttc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          // table is built lazily on the first request after reset or a key or direction write
          state_nxt  = status.tbl_ready ? ttc_pkg::ST_LOOK : ttc_pkg::ST_CLEAR;
        end
      end
      ttc_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = ttc_pkg::ST_KEY;
      end
      ttc_pkg::ST_KEY: begin
        cmd.key_step = 1'b1;
        if (status.key_fail) begin
          state_nxt = ttc_pkg::ST_LOOK;
        end else if (status.key_last) begin
          state_nxt = ttc_pkg::ST_FILL;
        end
      end
      ttc_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_nxt = ttc_pkg::ST_LOOK;
        end
      end
      ttc_pkg::ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ttc_pkg::ST_POS;
      end
      ttc_pkg::ST_POS: begin
        cmd.pos   = 1'b1;
        state_nxt = ttc_pkg::ST_MAP;
      end
      ttc_pkg::ST_MAP: begin
        if (status.out_free) begin
          cmd.map_load = 1'b1;
          state_nxt    = ttc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ttc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/ttc_datapath.sv -----
// ttc_datapath: key registers, table build counters, the two table RAMs and output register.
// Depends on ttc_pkg and ttc_ram; commanded by ttc_ctrl.

module ttc_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ttc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ttc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [ttc_pkg::CHAR_W-1:0]       char_in,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [ttc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  ttc_pkg::cmd_t                    cmd,
  output ttc_pkg::status_t                 status
);

  localparam int LW = ttc_pkg::LETTER_W;

  logic [LW-1:0]                   key_r [ttc_pkg::KEY_LENGTH];
  logic                            dir_r;
  logic                            tbl_ready_r;
  logic                            bad_r;
  logic [ttc_pkg::ALPHA_SIZE-1:0]  used_r;
  logic [LW-1:0]                   cnt_r;
  logic [LW-1:0]                   pos_r;
  logic [ttc_pkg::CHAR_W-1:0]      char_r;
  logic                            hit_r;
  logic                            out_valid_r;
  logic [ttc_pkg::CHAR_W-1:0]      out_char_r;
  logic                            out_err_r;

  logic [LW-1:0]                   key_cur;
  logic                            key_fail;
  ttc_pkg::alpha_hit_t             look;
  logic [LW:0]                     np_sum;
  logic [LW-1:0]                   np;

  logic                            lap_we, pol_we;
  logic [LW-1:0]                   lap_waddr, lap_wdata, pol_waddr, pol_wdata;
  logic [LW-1:0]                   pol_rdata, lap_rdata;

  assign key_cur  = key_r[cnt_r[ttc_pkg::KEY_IDX_W-1:0]];
  assign key_fail = (key_cur >= LW'(ttc_pkg::ALPHA_SIZE)) ? 1'b1 : used_r[key_cur];
  assign look     = ttc_pkg::alpha_lookup(char_r);

  // next table position, one row down or up with wraparound
  assign np_sum = {1'b0, pol_rdata} + (dir_r ? ttc_pkg::STEP_DOWN : ttc_pkg::STEP_UP);
  assign np     = (np_sum >= (LW+1)'(ttc_pkg::ALPHA_SIZE))
                  ? LW'(np_sum - (LW+1)'(ttc_pkg::ALPHA_SIZE)) : np_sum[LW-1:0];

  always_comb begin
    lap_we    = 1'b0;
    pol_we    = 1'b0;
    lap_waddr = pos_r;
    pol_wdata = pos_r;
    lap_wdata = cnt_r;
    pol_waddr = cnt_r;
    if (cmd.key_step && !key_fail) begin
      lap_we    = 1'b1;
      pol_we    = 1'b1;
      lap_wdata = key_cur;
      pol_waddr = key_cur;
    end else if (cmd.fill_step && !used_r[cnt_r]) begin
      lap_we = 1'b1;
      pol_we = 1'b1;
    end
  end

  ttc_ram #(.WIDTH(LW), .DEPTH(ttc_pkg::ALPHA_SIZE)) u_pol_ram (
    .clk   (clk),
    .we    (pol_we),
    .waddr (pol_waddr),
    .wdata (pol_wdata),
    .re    (cmd.look),
    .raddr (look.idx),
    .rdata (pol_rdata)
  );

  ttc_ram #(.WIDTH(LW), .DEPTH(ttc_pkg::ALPHA_SIZE)) u_lap_ram (
    .clk   (clk),
    .we    (lap_we),
    .waddr (lap_waddr),
    .wdata (lap_wdata),
    .re    (cmd.pos),
    .raddr (np),
    .rdata (lap_rdata)
  );

  // configuration and table status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]    <= 5'd5;
      key_r[1]    <= 5'd14;
      key_r[2]    <= 5'd9;
      key_r[3]    <= 5'd7;
      key_r[4]    <= 5'd13;
      key_r[5]    <= 5'd0;
      dir_r       <= 1'b1;
      tbl_ready_r <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr <= ttc_pkg::REG_KEY_LAST) begin
          key_r[cfg_addr] <= cfg_wdata;
          tbl_ready_r     <= 1'b0;
        end else if (cfg_addr == ttc_pkg::REG_DIRECTION) begin
          dir_r       <= cfg_wdata[0];
          tbl_ready_r <= 1'b0;
        end
      end
      if (cmd.clear) begin
        bad_r <= 1'b0;
      end
      if (cmd.key_step && key_fail) begin
        bad_r       <= 1'b1;
        tbl_ready_r <= 1'b1;
      end
      if (cmd.fill_step && cnt_r == LW'(ttc_pkg::ALPHA_SIZE - 1)) begin
        tbl_ready_r <= 1'b1;
      end
    end
  end

  // build counters and used marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      cnt_r  <= '0;
      pos_r  <= '0;
    end else if (cmd.clear) begin
      used_r <= '0;
      cnt_r  <= '0;
      pos_r  <= '0;
    end else if (cmd.key_step && !key_fail) begin
      used_r[key_cur] <= 1'b1;
      pos_r           <= pos_r + 1'b1;
      cnt_r           <= status.key_last ? '0 : cnt_r + 1'b1;
    end else if (cmd.fill_step) begin
      if (!used_r[cnt_r]) begin
        pos_r <= pos_r + 1'b1;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_r <= ttc_pkg::to_upper(char_in);
    end
    if (cmd.look) begin
      hit_r <= look.hit && !bad_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.map_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_load) begin
      out_char_r <= hit_r ? ttc_pkg::alpha_code(lap_rdata) : char_r;
      out_err_r  <= bad_r;
    end
  end

  assign status.tbl_ready = tbl_ready_r;
  assign status.key_fail  = key_fail;
  assign status.key_last  = (cnt_r == LW'(ttc_pkg::KEY_LENGTH - 1));
  assign status.fill_last = (cnt_r == LW'(ttc_pkg::ALPHA_SIZE - 1));
  assign status.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ttc_pkg::OUT_DATA_W - ttc_pkg::CHAR_W - 1){1'b0}},
                       out_err_r, out_char_r};

endmodule

// ----- rtl/trisemus_table_cipher.sv -----
// Keyword-table substitution over the 30-letter German alphabet (5x6 table).
// A request goes from acceptance to a loaded result in order: accept it,
// read the letter's table position, step a row and read the letter there,
// and load the output register once it is free. The first request after
// reset or after a key or direction write first rebuilds the table (a
// clear, a step per keyword letter, then fill steps through the alphabet),
// cut short when a keyword letter is repeated or out of range, in which
// case every character comes back upper-cased only with key_error set.
// in_tready is low while a request is in work; a finished result waits in
// the output register.
// Depends on ttc_pkg, ttc_ctrl, ttc_datapath and ttc_ram.

module trisemus_table_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ttc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ttc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ttc_pkg::CHAR_W-1:0]     in_tdata,   // [15:0] char_in
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ttc_pkg::OUT_DATA_W-1:0] out_tdata   // [15:0] char_out, [16] key_error
);

  ttc_pkg::cmd_t    cmd;
  ttc_pkg::status_t status;

  ttc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ttc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .char_in    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
